[design/kclc_pkg.sv]
// Shared types, codes and constants for the keypad code lock controller.
// Used by kclc_front, kclc_back and keypad_code_lock_controller; no dependencies.
package kclc_pkg;

	// Digits in one code entry
	localparam int CODE_LENGTH = 4;
	localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
	localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

	// Field widths
	localparam int DIGIT_W  = 3;
	localparam int ATT_W    = 3;
	localparam int CD_W     = 8;
	localparam int STATUS_W = 4;
	localparam int MODE_W   = 2;
	localparam int OP_W     = 2;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_SECONDS = 2'd1;
	localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RESET    = 3'd3;
	localparam logic [CD_W-1:0]  LOCKOUT_SECONDS_RESET = 8'd10;

	// Queue between front and back, and result queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Input op codes
	localparam logic [OP_W-1:0] OP_PRESS  = 2'd0;
	localparam logic [OP_W-1:0] OP_CHANGE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	// Valid button numbers
	localparam logic [DIGIT_W-1:0] BTN_LOW  = 3'd1;
	localparam logic [DIGIT_W-1:0] BTN_HIGH = 3'd4;

	// Classified command kinds
	localparam logic [1:0] CMD_NOP    = 2'd0;
	localparam logic [1:0] CMD_PRESS  = 2'd1;
	localparam logic [1:0] CMD_CHANGE = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	// Lock modes
	localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VERIFY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NEWCODE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LOCKED  = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_TAKEN    = 4'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED  = 4'd1;
	localparam logic [STATUS_W-1:0] ST_DENIED   = 4'd2;
	localparam logic [STATUS_W-1:0] ST_LOCKED   = 4'd3;
	localparam logic [STATUS_W-1:0] ST_TICK     = 4'd4;
	localparam logic [STATUS_W-1:0] ST_DONE     = 4'd5;
	localparam logic [STATUS_W-1:0] ST_VERIFIED = 4'd6;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CHANGED  = 4'd8;
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 4'd9;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DIGIT_W-1:0] button;
	} kclc_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ATT_W-1:0]    attempts_left;
		logic [CD_W-1:0]     cooldown_left;
		logic [MODE_W-1:0]   mode_now;
		logic [2:0]          digits_entered;
	} kclc_out_t;

	typedef struct packed {
		logic [1:0] kind;
		digit_t     digit;
	} kclc_cmd_t;

	// Stored code after reset
	function automatic digit_t code_reset(input int i);
		digit_t d;
		case (i)
			0: d = 3'd1;
			1: d = 3'd2;
			2: d = 3'd3;
			3: d = 3'd4;
			default: d = 3'd0;
		endcase
		return d;
	endfunction

endpackage

[design/keypad_code_lock_controller.sv]
// Top level of the keypad code lock controller: front end, back end and checks.
// Depends on kclc_pkg, kclc_front and kclc_back.
//
// Usage:
//   Input side is a queue: drive request (op, button) with push; the item is
//   taken on a clock edge where push is high and full is low.
//   Result side is a queue: while empty is low, result holds the oldest
//   result item (status, attempts, cooldown, mode, digit count); pop takes it.
//   Every input item yields exactly one result item, in order.
//   Configuration: cfg_we with cfg_index 0 (max_attempts) or 1
//   (lockout_seconds) and cfg_data; write only while the block is idle.
// Timing:
//   An item's result is registered: it sits at the head of the command queue
//   while the back end updates the lock state, and enters the result queue
//   when the back end takes it, once the result queue has room.
//   One item per cycle is sustained while the receiver keeps popping.
//   Both queues hold two items; when the receiver stops popping, the result
//   queue fills, the back end holds, then the command queue fills and full
//   rises. Nothing is lost.
// Reset:
//   arst_n clears the queues, loads code 1,2,3,4, three attempts, a
//   ten-tick lockout and normal mode.
module keypad_code_lock_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  kclc_pkg::kclc_in_t               request,
	output logic                             full,
	input  logic                             pop,
	output logic                             empty,
	output kclc_pkg::kclc_out_t              result,
	input  logic                             cfg_we,
	input  logic [kclc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [kclc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                cmd_valid;
	logic                cmd_take;
	kclc_pkg::kclc_cmd_t cmd;

	// Accept and classify items
	kclc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.request   (request),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// Carry out commands and queue results
	kclc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

`ifndef SYNTHESIS
	// The back end never takes from an empty command queue
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from empty queue");

	// Locked mode only with attempts used up
	a_locked_att: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mode_now == kclc_pkg::MODE_LOCKED) |-> (result.attempts_left == '0))
		else $error("locked with attempts left");

	// A lockout status always reports locked mode
	a_lock_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == kclc_pkg::ST_LOCKED || result.status == kclc_pkg::ST_TICK))
		|-> (result.mode_now == kclc_pkg::MODE_LOCKED))
		else $error("lockout status outside locked mode");

	// A full entry is always consumed, so the count stays below the code length
	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(result.digits_entered) < kclc_pkg::CODE_LENGTH))
		else $error("digit count reached code length");
`endif

endmodule

[design/kclc_front.sv]
// Front end of the keypad code lock: accepts input items, classifies them
// and holds them in a short command queue. Depends on kclc_pkg.
module kclc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kclc_pkg::kclc_in_t request,
	output logic               full,
	output logic               cmd_valid,
	output kclc_pkg::kclc_cmd_t cmd,
	input  logic               cmd_take
);

	kclc_pkg::kclc_cmd_t               cls;
	kclc_pkg::kclc_cmd_t               q_mem_q [kclc_pkg::QDEPTH];
	logic [kclc_pkg::QPTR_W-1:0]       wr_q;
	logic [kclc_pkg::QPTR_W-1:0]       rd_q;
	logic [kclc_pkg::QCNT_W-1:0]       cnt_q;
	logic                              do_push;

	// Classify the incoming item
	always_comb begin
		cls.digit = request.button;
		case (request.op)
			kclc_pkg::OP_PRESS: begin
				if (request.button inside {[kclc_pkg::BTN_LOW:kclc_pkg::BTN_HIGH]})
					cls.kind = kclc_pkg::CMD_PRESS;
				else
					cls.kind = kclc_pkg::CMD_NOP;
			end
			kclc_pkg::OP_CHANGE: cls.kind = kclc_pkg::CMD_CHANGE;
			kclc_pkg::OP_TICK:   cls.kind = kclc_pkg::CMD_TICK;
			default:             cls.kind = kclc_pkg::CMD_NOP;
		endcase
	end

	assign full      = (cnt_q == kclc_pkg::QCNT_W'(kclc_pkg::QDEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem_q[rd_q];

	// Queue payload
	always_ff @(posedge clk) begin
		if (do_push)
			q_mem_q[wr_q] <= cls;
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (cmd_take)
				rd_q <= rd_q + 1'b1;
			if (do_push && !cmd_take)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && cmd_take)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[design/kclc_back.sv]
// Back end of the keypad code lock: configuration registers, lock state
// update for each command, and the result queue. Depends on kclc_pkg.
module kclc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [kclc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [kclc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 cmd_valid,
	input  kclc_pkg::kclc_cmd_t                  cmd,
	output logic                                 cmd_take,
	input  logic                                 pop,
	output logic                                 empty,
	output kclc_pkg::kclc_out_t                  result
);

	logic [kclc_pkg::ATT_W-1:0]   max_att_q;
	logic [kclc_pkg::CD_W-1:0]    lockout_q;

	kclc_pkg::digit_t             stored_q [kclc_pkg::CODE_LENGTH];
	kclc_pkg::digit_t             entry_q  [kclc_pkg::CODE_LENGTH];
	kclc_pkg::digit_t             full_entry [kclc_pkg::CODE_LENGTH];
	logic [kclc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [kclc_pkg::ATT_W-1:0]   att_q, att_d;
	logic [kclc_pkg::MODE_W-1:0]  mode_q, mode_d;
	logic [kclc_pkg::CD_W-1:0]    cd_q, cd_d, cd_dec;
	logic [kclc_pkg::ATT_W-1:0]   att_dec;
	logic [kclc_pkg::STATUS_W-1:0] status;
	logic [kclc_pkg::IDX_W-1:0]   idx;
	logic                         match;
	logic                         entry_we;
	logic                         stored_we;

	kclc_pkg::kclc_out_t          res_mem_q [kclc_pkg::QDEPTH];
	logic [kclc_pkg::QPTR_W-1:0]  res_wr_q;
	logic [kclc_pkg::QPTR_W-1:0]  res_rd_q;
	logic [kclc_pkg::QCNT_W-1:0]  res_cnt_q;
	logic                         do_pop;
	kclc_pkg::kclc_out_t          res_new;

	// Result queue handshake; take a command when a slot is free or a pop frees one
	assign empty    = (res_cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign result   = res_mem_q[res_rd_q];
	assign cmd_take = cmd_valid &&
		((res_cnt_q != kclc_pkg::QCNT_W'(kclc_pkg::QDEPTH)) || do_pop);

	// Build the entry as it stands with this digit, and compare
	assign idx = cnt_q[kclc_pkg::IDX_W-1:0];
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < kclc_pkg::CODE_LENGTH; i++) begin
			full_entry[i] = (idx == kclc_pkg::IDX_W'(i)) ? cmd.digit : entry_q[i];
			if (full_entry[i] != stored_q[i])
				match = 1'b0;
		end
	end

	assign att_dec = (att_q != '0) ? att_q - 1'b1 : att_q;
	assign cd_dec  = (cd_q != '0) ? cd_q - 1'b1 : cd_q;

	// Next lock state and status for the command at the queue head
	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		att_d     = att_q;
		cd_d      = cd_q;
		entry_we  = 1'b0;
		stored_we = 1'b0;
		status    = kclc_pkg::ST_IGNORED;
		case (cmd.kind)
			kclc_pkg::CMD_PRESS: begin
				if (mode_q != kclc_pkg::MODE_LOCKED) begin
					entry_we = 1'b1;
					if (cnt_q != kclc_pkg::CNT_W'(kclc_pkg::CODE_LENGTH - 1)) begin
						cnt_d  = cnt_q + 1'b1;
						status = kclc_pkg::ST_TAKEN;
					end else begin
						cnt_d = '0;
						case (mode_q)
							kclc_pkg::MODE_NORMAL: begin
								if (match) begin
									att_d  = max_att_q;
									status = kclc_pkg::ST_GRANTED;
								end else if (att_dec == '0) begin
									att_d  = att_dec;
									mode_d = kclc_pkg::MODE_LOCKED;
									cd_d   = lockout_q;
									status = kclc_pkg::ST_LOCKED;
								end else begin
									att_d  = att_dec;
									status = kclc_pkg::ST_DENIED;
								end
							end
							kclc_pkg::MODE_VERIFY: begin
								if (match) begin
									mode_d = kclc_pkg::MODE_NEWCODE;
									status = kclc_pkg::ST_VERIFIED;
								end else begin
									mode_d = kclc_pkg::MODE_NORMAL;
									att_d  = max_att_q;
									status = kclc_pkg::ST_REJECTED;
								end
							end
							default: begin
								stored_we = 1'b1;
								mode_d    = kclc_pkg::MODE_NORMAL;
								att_d     = max_att_q;
								status    = kclc_pkg::ST_CHANGED;
							end
						endcase
					end
				end
			end
			kclc_pkg::CMD_CHANGE: begin
				if (mode_q == kclc_pkg::MODE_NORMAL && cnt_q == '0) begin
					mode_d = kclc_pkg::MODE_VERIFY;
					status = kclc_pkg::ST_TAKEN;
				end
			end
			kclc_pkg::CMD_TICK: begin
				if (mode_q == kclc_pkg::MODE_LOCKED) begin
					cd_d = cd_dec;
					if (cd_dec != '0) begin
						status = kclc_pkg::ST_TICK;
					end else begin
						mode_d = kclc_pkg::MODE_NORMAL;
						cnt_d  = '0;
						att_d  = max_att_q;
						status = kclc_pkg::ST_DONE;
					end
				end
			end
			default: status = kclc_pkg::ST_IGNORED;
		endcase
	end

	// Result item for this step
	always_comb begin
		res_new.status         = status;
		res_new.attempts_left  = att_d;
		res_new.cooldown_left  = cd_d;
		res_new.mode_now       = mode_d;
		res_new.digits_entered = 3'(cnt_d);
	end

	// Entry digits and result payload hold no reset
	always_ff @(posedge clk) begin
		if (cmd_take && entry_we)
			entry_q[idx] <= cmd.digit;
		if (cmd_take)
			res_mem_q[res_wr_q] <= res_new;
	end

	// Configuration, lock state, stored code and result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= kclc_pkg::MAX_ATTEMPTS_RESET;
			lockout_q <= kclc_pkg::LOCKOUT_SECONDS_RESET;
			for (int i = 0; i < kclc_pkg::CODE_LENGTH; i++)
				stored_q[i] <= kclc_pkg::code_reset(i);
			cnt_q     <= '0;
			att_q     <= kclc_pkg::MAX_ATTEMPTS_RESET;
			mode_q    <= kclc_pkg::MODE_NORMAL;
			cd_q      <= '0;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kclc_pkg::REG_MAX_ATTEMPTS:    max_att_q <= cfg_data[kclc_pkg::ATT_W-1:0];
					kclc_pkg::REG_LOCKOUT_SECONDS: lockout_q <= cfg_data[kclc_pkg::CD_W-1:0];
					default: ;
				endcase
			end
			if (cmd_take) begin
				cnt_q    <= cnt_d;
				att_q    <= att_d;
				mode_q   <= mode_d;
				cd_q     <= cd_d;
				res_wr_q <= res_wr_q + 1'b1;
				if (stored_we) begin
					for (int i = 0; i < kclc_pkg::CODE_LENGTH; i++)
						stored_q[i] <= full_entry[i];
				end
			end
			if (do_pop)
				res_rd_q <= res_rd_q + 1'b1;
			if (cmd_take && !do_pop)
				res_cnt_q <= res_cnt_q + 1'b1;
			else if (!cmd_take && do_pop)
				res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

endmodule

[dv/tb.sv]
// Self-checking testbench for keypad_code_lock_controller: queue driver, queue monitor,
// in-order prediction of every result item, and a cycle watchdog.
// Depends on kclc_pkg and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kclc_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES  = 120;
	localparam int QUIET_LIMIT  = 3000;

	typedef logic [CODE_LENGTH-1:0][DIGIT_W-1:0] code_t;

	// Lock state and register copies, advanced one item at a time
	typedef struct packed {
		code_t              code;
		code_t              entry;
		logic [2:0]         count;
		logic [ATT_W-1:0]   attempts;
		logic [MODE_W-1:0]  mode;
		logic [CD_W-1:0]    cooldown;
		logic [ATT_W-1:0]   max_att;
		logic [CD_W-1:0]    lockout;
	} lock_state_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	kclc_in_t               request = '0;
	logic                   full;
	logic                   pop = 1'b0;
	logic                   empty;
	kclc_out_t              result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	kclc_in_t    pending[$];
	kclc_out_t   expected_results[$];
	lock_state_t model;
	lock_state_t plan;
	int          errors = 0;
	int          live_items = 0;
	int          results_seen = 0;
	int          hold_token = 0;

	keypad_code_lock_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .request(request), .full(full),
		.pop(pop), .empty(empty), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lock_state_t reset_state();
		lock_state_t s;
		s = '0;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			s.code[i] = DIGIT_W'(i + 1);
		end
		s.max_att  = 3'd3;
		s.lockout  = 8'd10;
		s.attempts = s.max_att;
		s.mode     = MODE_NORMAL;
		return s;
	endfunction

	// Apply one item to a lock state and return the result item it yields
	function automatic kclc_out_t lock_step(inout lock_state_t s, input kclc_in_t it);
		logic [STATUS_W-1:0] st;
		kclc_out_t r;
		st = ST_IGNORED;
		case (it.op)
			OP_PRESS: begin
				if (it.button >= BTN_LOW && it.button <= BTN_HIGH && s.mode != MODE_LOCKED) begin
					s.entry[s.count[1:0]] = it.button;
					s.count = s.count + 3'd1;
					if (s.count < CODE_LENGTH) begin
						st = ST_TAKEN;
					end else begin
						s.count = '0;
						case (s.mode)
							MODE_NORMAL: begin
								if (s.entry == s.code) begin
									s.attempts = s.max_att;
									st = ST_GRANTED;
								end else begin
									// Saturate at zero, then lock
									if (s.attempts != 0) s.attempts = s.attempts - 3'd1;
									if (s.attempts == 0) begin
										s.mode = MODE_LOCKED;
										s.cooldown = s.lockout;
										st = ST_LOCKED;
									end else begin
										st = ST_DENIED;
									end
								end
							end
							MODE_VERIFY: begin
								if (s.entry == s.code) begin
									s.mode = MODE_NEWCODE;
									st = ST_VERIFIED;
								end else begin
									s.mode = MODE_NORMAL;
									s.attempts = s.max_att;
									st = ST_REJECTED;
								end
							end
							default: begin
								s.code = s.entry;
								s.mode = MODE_NORMAL;
								s.attempts = s.max_att;
								st = ST_CHANGED;
							end
						endcase
					end
				end
			end
			OP_CHANGE: begin
				if (s.mode == MODE_NORMAL && s.count == 0) begin
					s.mode = MODE_VERIFY;
					st = ST_TAKEN;
				end
			end
			OP_TICK: begin
				if (s.mode == MODE_LOCKED) begin
					if (s.cooldown != 0) s.cooldown = s.cooldown - 8'd1;
					if (s.cooldown != 0) begin
						st = ST_TICK;
					end else begin
						s.mode = MODE_NORMAL;
						s.count = '0;
						s.attempts = s.max_att;
						st = ST_DONE;
					end
				end
			end
			default: st = ST_IGNORED;
		endcase
		r.status         = st;
		r.attempts_left  = s.attempts;
		r.cooldown_left  = s.cooldown;
		r.mode_now       = s.mode;
		r.digits_entered = s.count;
		return r;
	endfunction

	// Idle length: mostly short, a few long, with the odd run of back-to-back items
	function automatic int draw_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic code_t random_code();
		code_t c;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			c[i] = DIGIT_W'($urandom_range(1, 4));
		end
		return c;
	endfunction

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	// Queue one item and track the state it leaves behind
	task automatic add_item(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] button);
		kclc_in_t it;
		kclc_out_t r;
		it.op = op;
		it.button = button;
		pending.push_back(it);
		r = lock_step(plan, it);
		if (r.status != ST_IGNORED) live_items++;
	endtask

	task automatic add_entry(input code_t c);
		for (int i = 0; i < CODE_LENGTH; i++) begin
			add_item(OP_PRESS, c[i]);
		end
	endtask

	task automatic add_noise();
		case ($urandom_range(0, 3))
			0: add_item(OP_PRESS, DIGIT_W'($urandom_range(5, 8)));
			1: add_item(OP_UNUSED, DIGIT_W'($urandom));
			2: add_item(OP_TICK, DIGIT_W'($urandom));
			default: add_item(OP_CHANGE, DIGIT_W'($urandom));
		endcase
	endtask

	// Pick the next sequence from the state the queued items will leave
	task automatic add_sequence();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (plan.mode == MODE_LOCKED) begin
			if (r < 85) add_item(OP_TICK, DIGIT_W'($urandom));
			else if (r < 95) add_item(OP_PRESS, DIGIT_W'($urandom_range(1, 4)));
			else add_noise();
		end else if (plan.count != 0) begin
			add_item(OP_PRESS, DIGIT_W'($urandom_range(1, 4)));
		end else if (plan.mode != MODE_NORMAL) begin
			add_entry((r < 70) ? plan.code : random_code());
		end else if (r < 30) begin
			add_entry(plan.code);
		end else if (r < 55) begin
			add_entry(random_code());
		end else if (r < 70) begin
			// Change the code: request, current code (now and then a wrong one), new code
			add_item(OP_CHANGE, DIGIT_W'($urandom));
			add_entry((r < 67) ? plan.code : random_code());
			add_entry(random_code());
		end else if (r < 82) begin
			// Break an entry with an interloper; later calls finish it
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				add_item(OP_PRESS, DIGIT_W'($urandom_range(1, 4)));
			end
			add_noise();
		end else begin
			add_noise();
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || push || expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_MAX_ATTEMPTS) model.max_att = data[ATT_W-1:0];
		else if (idx == REG_LOCKOUT_SECONDS) model.lockout = data;
		plan = model;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: predict each accepted item, then offer the next one
	int tx_gap = 0;
	int tx_burst = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) expected_results.push_back(lock_step(model, request));
			if (!push || !full) begin
				if (tx_gap > 0) begin
					push <= 1'b0;
					tx_gap--;
				end else if (pending.size() != 0) begin
					request <= pending.pop_front();
					push <= 1'b1;
					tx_gap = draw_gap(tx_burst);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result item, then decide on pop
	int rx_stall = 0;
	int rx_burst = 0;
	int hold_left = 0;
	int hold_seen = 0;
	kclc_out_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", results_seen));
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status)
						report($sformatf("result %0d status %0d, want %0d",
							results_seen, result.status, want.status));
					if (result.attempts_left !== want.attempts_left)
						report($sformatf("result %0d attempts_left %0d, want %0d",
							results_seen, result.attempts_left, want.attempts_left));
					if (result.cooldown_left !== want.cooldown_left)
						report($sformatf("result %0d cooldown_left %0d, want %0d",
							results_seen, result.cooldown_left, want.cooldown_left));
					if (result.mode_now !== want.mode_now)
						report($sformatf("result %0d mode_now %0d, want %0d",
							results_seen, result.mode_now, want.mode_now));
					if (result.digits_entered !== want.digits_entered)
						report($sformatf("result %0d digits_entered %0d, want %0d",
							results_seen, result.digits_entered, want.digits_entered));
				end
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (hold_token != hold_seen) begin
				// Long hold-off so the block fills and raises full
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else if (rx_stall > 0) begin
				pop <= 1'b0;
				rx_stall--;
			end else if (pop && !empty) begin
				rx_stall = draw_gap(rx_burst);
				if (rx_stall > 0) begin
					rx_stall--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int len;
		int start;
		int r;
		model = reset_state();
		plan = model;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: grant at reset code, ignored items, code change
		add_entry({3'd4, 3'd3, 3'd2, 3'd1});
		add_item(OP_PRESS, 3'd0);
		add_item(OP_PRESS, 3'd7);
		add_item(OP_UNUSED, 3'd6);
		add_item(OP_TICK, 3'd5);
		add_item(OP_CHANGE, 3'd2);
		add_entry({3'd4, 3'd3, 3'd2, 3'd1});
		add_entry({3'd1, 3'd2, 3'd3, 3'd4});
		wait_drained();

		// Directed: max attempts 1 and lockout 1 written, then a wrong entry, a press and a tick
		write_reg(REG_MAX_ATTEMPTS, 8'd1);
		write_reg(REG_LOCKOUT_SECONDS, 8'd1);
		add_entry({3'd1, 3'd1, 3'd1, 3'd1});
		add_item(OP_PRESS, 3'd4);
		add_item(OP_TICK, 3'd0);
		wait_drained();

		// Random phases, with register changes only between them
		live_items = 0;
		phase = 0;
		while (live_items < RANDOM_ITEMS) begin
			wait_drained();
			repeat (3) @(posedge clk);
			if (phase == 1) begin
				write_reg(REG_MAX_ATTEMPTS, 8'd7);
			end else if (phase == 5) begin
				write_reg(REG_MAX_ATTEMPTS, 8'd1);
				write_reg(REG_LOCKOUT_SECONDS, 8'd255);
			end else if (phase == 6) begin
				write_reg(REG_LOCKOUT_SECONDS, 8'd4);
			end else if ($urandom_range(0, 99) < 40) begin
				r = $urandom_range(0, 9);
				if (r < 2) write_reg(REG_MAX_ATTEMPTS, 8'd1);
				else if (r < 4) write_reg(REG_MAX_ATTEMPTS, 8'd7);
				else if (r < 5) write_reg(REG_MAX_ATTEMPTS, CFG_DATA_W'($urandom));
				else write_reg(REG_MAX_ATTEMPTS, CFG_DATA_W'($urandom_range(1, 7)));
				r = $urandom_range(0, 9);
				if (r < 1) write_reg(REG_LOCKOUT_SECONDS, 8'd0);
				else if (r < 2) write_reg(REG_LOCKOUT_SECONDS, 8'd1);
				else write_reg(REG_LOCKOUT_SECONDS, CFG_DATA_W'($urandom_range(1, 12)));
				if ($urandom_range(0, 99) < 20)
					write_reg(CFG_INDEX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
			end
			if (phase == 2) hold_token++;
			len = (phase == 2) ? 80 : $urandom_range(15, 60);
			start = live_items;
			while (live_items - start < len) add_sequence();
			phase++;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

endmodule
